[src/gep_pkg.sv]
// Shared constants, types and helper functions of the glowing-eye pixel generator.
// No dependencies; the interfaces and the core module use it by scoped names.
package gep_pkg;

	localparam int FRAME_WIDTH  = 448;
	localparam int FRAME_HEIGHT = 368;

	localparam int NUM_EYES   = 2;
	localparam int NUM_LAYERS = 3;

	// Layer order is also paint order: the later layer wins.
	localparam int LAYER_OUTER = 0;
	localparam int LAYER_INNER = 1;
	localparam int LAYER_CORE  = 2;

	localparam int EYE_LEFT  = 0;
	localparam int EYE_RIGHT = 1;

	localparam logic [15:0] COLOR_OUTER = 16'h0130;
	localparam logic [15:0] COLOR_INNER = 16'h03BF;
	localparam logic [15:0] COLOR_CORE  = 16'h05FF;
	localparam logic [15:0] COLOR_BLACK = 16'h0000;

	localparam logic [3:0] GROW_OUTER = 4'd12;
	localparam logic [3:0] GROW_INNER = 4'd6;
	localparam logic [3:0] GROW_CORE  = 4'd0;

	localparam logic [5:0] BROW_ROWS    = 6'd35;
	localparam logic [7:0] BLINK_HEIGHT = 8'd8;

	typedef enum logic [2:0] {
		REG_LEFT_X        = 3'd0,
		REG_RIGHT_X       = 3'd1,
		REG_EYE_TOP       = 3'd2,
		REG_EYE_WIDTH     = 3'd3,
		REG_EYE_HEIGHT    = 3'd4,
		REG_CORNER_RADIUS = 3'd5,
		REG_BROW_TILT     = 3'd6,
		REG_BLINK_CLOSED  = 3'd7
	} cfg_reg_t;

	typedef logic [8:0]         coord_t;
	typedef logic [15:0]        color_t;
	// Signed working width for all geometry: 11 bits, covers -1024 .. 1023.
	typedef logic signed [10:0] geom_t;
	// Distance to the corner-circle center; at most r + 2*grow = 87 inside the box.
	typedef logic [6:0]         dist_t;
	typedef logic [13:0]        dsq_t;

	function automatic logic [3:0] layer_grow(input int layer);
		logic [3:0] g;
		case (layer)
			LAYER_OUTER: g = GROW_OUTER;
			LAYER_INNER: g = GROW_INNER;
			default:     g = GROW_CORE;
		endcase
		return g;
	endfunction

	function automatic color_t layer_color(input int layer);
		color_t c;
		case (layer)
			LAYER_OUTER: c = COLOR_OUTER;
			LAYER_INNER: c = COLOR_INNER;
			default:     c = COLOR_CORE;
		endcase
		return c;
	endfunction

endpackage

[src/gep_pixel_if.sv]
// Request channel carrying one pixel coordinate with valid/ready handshake.
// Depends on gep_pkg for the coordinate type.
interface gep_pixel_if;
	logic          valid;
	logic          ready;
	gep_pkg::coord_t pixel_x;
	gep_pkg::coord_t pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

[src/gep_color_if.sv]
// Result channel carrying one RGB565 pixel color with valid/ready handshake.
// Depends on gep_pkg for the color type.
interface gep_color_if;
	logic          valid;
	logic          ready;
	gep_pkg::color_t pixel_color;

	modport source (output valid, output pixel_color, input ready);
	modport sink   (input valid, input pixel_color, output ready);
endinterface

[src/glowing_eye_pixel_generator_core.sv]
// Glowing-eye pixel generator: for each pixel request returns the RGB565 color of two
// rounded-rectangle eyes with outer glow, inner glow and cyan core, plus an optional brow cut.
// Depends on gep_pkg, gep_pixel_if and gep_color_if.
//
// It takes one pixel request per clock unless the output stalls and returns colors in order.
// Stage one computes box tests, corner distances and the brow test for all six layers in
// parallel, stage two squares the distances, stage three compares against the squared
// radius and resolves paint order, and the fourth register holds the result for the sink.
// Each stage holds its item when the next one is full, so back-pressure stalls without
// loss and bubbles are squeezed out. Configuration registers are used live by the stages
// and must be written only while no request is in flight.
module glowing_eye_pixel_generator_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_idx,
	input  logic [8:0]             cfg_data,
	gep_pixel_if.sink              pixel_in,
	gep_color_if.source            color_out
);

	// Configuration registers.
	logic [8:0] left_x_q, right_x_q, eye_top_q;
	logic [7:0] eye_width_q, eye_height_q;
	logic [5:0] corner_radius_q, brow_tilt_q;
	logic       blink_closed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_x_q        <= 9'd96;
			right_x_q       <= 9'd232;
			eye_top_q       <= 9'd99;
			eye_width_q     <= 8'd120;
			eye_height_q    <= 8'd168;
			corner_radius_q <= 6'd38;
			brow_tilt_q     <= 6'd0;
			blink_closed_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (gep_pkg::cfg_reg_t'(cfg_idx))
				gep_pkg::REG_LEFT_X:        left_x_q        <= cfg_data;
				gep_pkg::REG_RIGHT_X:       right_x_q       <= cfg_data;
				gep_pkg::REG_EYE_TOP:       eye_top_q       <= cfg_data;
				gep_pkg::REG_EYE_WIDTH:     eye_width_q     <= cfg_data[7:0];
				gep_pkg::REG_EYE_HEIGHT:    eye_height_q    <= cfg_data[7:0];
				gep_pkg::REG_CORNER_RADIUS: corner_radius_q <= cfg_data[5:0];
				gep_pkg::REG_BROW_TILT:     brow_tilt_q     <= cfg_data[5:0];
				gep_pkg::REG_BLINK_CLOSED:  blink_closed_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control: a stage loads when it is empty or its content moves on.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic load_s1, load_s2, load_s3, load_s4;

	assign load_s4 = !valid_s4 || color_out.ready;
	assign load_s3 = !valid_s3 || load_s4;
	assign load_s2 = !valid_s2 || load_s3;
	assign load_s1 = !valid_s1 || load_s2;

	assign pixel_in.ready  = load_s1;
	assign color_out.valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= pixel_in.valid;
			if (load_s2) valid_s2 <= valid_s1;
			if (load_s3) valid_s3 <= valid_s2;
			if (load_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: input coordinates.
	gep_pkg::coord_t px_s1, py_s1;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			px_s1 <= pixel_in.pixel_x;
			py_s1 <= pixel_in.pixel_y;
		end
	end

	// Stage 1 logic: box tests, corner distances and brow tests.
	logic          box_c   [gep_pkg::NUM_EYES][gep_pkg::NUM_LAYERS];
	gep_pkg::dist_t dx_c   [gep_pkg::NUM_EYES][gep_pkg::NUM_LAYERS];
	gep_pkg::dist_t dy_c   [gep_pkg::NUM_EYES][gep_pkg::NUM_LAYERS];
	logic          brow_c  [gep_pkg::NUM_EYES];
	logic          inframe_c;

	always_comb begin
		gep_pkg::geom_t px, py, ex, ey, ew, eh, g, rad, r, tilt;
		gep_pkg::geom_t ax, bx, ay, by, dxw, dyw, cx, cy, cxm, half_w;
		px     = gep_pkg::geom_t'({2'b00, px_s1});
		py     = gep_pkg::geom_t'({2'b00, py_s1});
		ey     = gep_pkg::geom_t'({2'b00, eye_top_q});
		ew     = gep_pkg::geom_t'({3'b000, eye_width_q});
		eh     = blink_closed_q ? gep_pkg::geom_t'({3'b000, gep_pkg::BLINK_HEIGHT})
		                        : gep_pkg::geom_t'({3'b000, eye_height_q});
		r      = gep_pkg::geom_t'({5'b00000, corner_radius_q});
		tilt   = gep_pkg::geom_t'({5'b00000, brow_tilt_q});
		half_w = gep_pkg::geom_t'({4'b0000, eye_width_q[7:1]});
		inframe_c = ({1'b0, px_s1} < 10'(gep_pkg::FRAME_WIDTH)) &&
		            ({1'b0, py_s1} < 10'(gep_pkg::FRAME_HEIGHT));
		for (int e = 0; e < gep_pkg::NUM_EYES; e++) begin
			ex = (e == gep_pkg::EYE_LEFT) ? gep_pkg::geom_t'({2'b00, left_x_q})
			                              : gep_pkg::geom_t'({2'b00, right_x_q});
			for (int l = 0; l < gep_pkg::NUM_LAYERS; l++) begin
				g   = gep_pkg::geom_t'({7'b0000000, gep_pkg::layer_grow(l)});
				rad = r + g;
				box_c[e][l] = (px >= ex - g) && (px < ex + ew + g) &&
				              (py >= ey - g) && (py < ey + eh + g);
				ax = ex + rad;
				bx = ex + ew - rad;
				ay = ey + rad;
				by = ey + eh - rad;
				if (px < ax)      dxw = ax - px;
				else if (px > bx) dxw = px - bx;
				else              dxw = '0;
				if (py < ay)      dyw = ay - py;
				else if (py > by) dyw = py - by;
				else              dyw = '0;
				// Inside the box both distances stay below 88, so seven bits suffice.
				dx_c[e][l] = dxw[6:0];
				dy_c[e][l] = dyw[6:0];
			end
			cx  = px - ex;
			cy  = py - ey;
			// The right eye's brow slants the other way.
			cxm = (e == gep_pkg::EYE_RIGHT) ? ew - 11'sd1 - cx : cx;
			brow_c[e] = (tilt != 11'sd0) && (cx >= 11'sd0) && (cx < ew) &&
			            (cy >= 11'sd0) &&
			            (cy < gep_pkg::geom_t'({5'b00000, gep_pkg::BROW_ROWS})) &&
			            (cxm > half_w - tilt + cy);
		end
	end

	// Stage 2: distances and hit flags.
	logic          box_s2  [gep_pkg::NUM_EYES][gep_pkg::NUM_LAYERS];
	gep_pkg::dist_t dx_s2  [gep_pkg::NUM_EYES][gep_pkg::NUM_LAYERS];
	gep_pkg::dist_t dy_s2  [gep_pkg::NUM_EYES][gep_pkg::NUM_LAYERS];
	logic          brow_s2 [gep_pkg::NUM_EYES];
	logic          inframe_s2;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			box_s2     <= box_c;
			dx_s2      <= dx_c;
			dy_s2      <= dy_c;
			brow_s2    <= brow_c;
			inframe_s2 <= inframe_c;
		end
	end

	// Stage 3: squared corner distances.
	logic          box_s3  [gep_pkg::NUM_EYES][gep_pkg::NUM_LAYERS];
	gep_pkg::dsq_t dsq_s3  [gep_pkg::NUM_EYES][gep_pkg::NUM_LAYERS];
	logic          brow_s3 [gep_pkg::NUM_EYES];
	logic          inframe_s3;

	always_ff @(posedge clk) begin
		if (load_s3) begin
			for (int e = 0; e < gep_pkg::NUM_EYES; e++) begin
				for (int l = 0; l < gep_pkg::NUM_LAYERS; l++) begin
					dsq_s3[e][l] <= ({7'b0, dx_s2[e][l]} * {7'b0, dx_s2[e][l]}) +
					                ({7'b0, dy_s2[e][l]} * {7'b0, dy_s2[e][l]});
				end
			end
			box_s3     <= box_s2;
			brow_s3    <= brow_s2;
			inframe_s3 <= inframe_s2;
		end
	end

	// Stage 3 logic: radius compare and paint order.
	gep_pkg::color_t color_c;
	logic            any_box_c;

	always_comb begin
		logic [6:0]    rad;
		gep_pkg::dsq_t rad_sq;
		color_c   = gep_pkg::COLOR_BLACK;
		any_box_c = 1'b0;
		for (int e = 0; e < gep_pkg::NUM_EYES; e++) begin
			for (int l = 0; l < gep_pkg::NUM_LAYERS; l++) begin
				rad    = {1'b0, corner_radius_q} + {3'b000, gep_pkg::layer_grow(l)};
				rad_sq = {7'b0, rad} * {7'b0, rad};
				any_box_c = any_box_c | box_s3[e][l];
				if (box_s3[e][l] && (dsq_s3[e][l] <= rad_sq))
					color_c = gep_pkg::layer_color(l);
			end
			if (brow_s3[e])
				color_c = gep_pkg::COLOR_BLACK;
		end
		if (!inframe_s3)
			color_c = gep_pkg::COLOR_BLACK;
	end

	// Stage 4: output register.
	gep_pkg::color_t color_s4;

	always_ff @(posedge clk) begin
		if (load_s4)
			color_s4 <= color_c;
	end

	assign color_out.pixel_color = color_s4;

	// A pixel outside the frame always comes out black.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && load_s4 && !inframe_s3) |=> (color_s4 == gep_pkg::COLOR_BLACK))
		else $error("out-of-frame pixel was painted");

	// A pixel outside every layer box of both eyes comes out black.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && load_s4 && !any_box_c) |=> (color_s4 == gep_pkg::COLOR_BLACK))
		else $error("pixel outside all boxes was painted");

	// A stalled first stage keeps its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load_s2) |=> (valid_s1 && $stable(px_s1) && $stable(py_s1)))
		else $error("stalled request lost in stage one");

	// A stalled third stage keeps its item and nothing overtakes it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !load_s4) |=> (valid_s3 && valid_s4 && $stable(inframe_s3)))
		else $error("stalled item lost in stage three");

	// An item leaving stage three always lands in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && load_s4) |=> valid_s4)
		else $error("item dropped between stage three and output");

endmodule
